>>> hw/rtl/glos_pkg.sv
package glos_pkg;

   localparam int WINDOW_SIDE  = 32;
   localparam int FLOOR_LAYERS = 16;

   localparam int COORD_W    = $clog2(WINDOW_SIDE);
   localparam int FLOOR_W    = 4;
   localparam int CELL_COUNT = WINDOW_SIDE * WINDOW_SIDE * FLOOR_LAYERS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   // line error magnitude stays below 2 * WINDOW_SIDE * (WINDOW_SIDE + 1)
   localparam int ERR_W      = 2 * COORD_W + 3;

   localparam int MARK_BLOCKS   = 0;
   localparam int MARK_OCCUPIED = 1;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   typedef struct packed {
      logic               operation;
      logic [COORD_W-1:0] from_x;
      logic [COORD_W-1:0] from_y;
      logic [FLOOR_W-1:0] from_z;
      logic [COORD_W-1:0] to_x;
      logic [COORD_W-1:0] to_y;
      logic [FLOOR_W-1:0] to_z;
      logic               floor_check;
      logic               cell_blocks;
      logic               cell_occupied;
   } req_type;

   typedef struct packed {
      logic sight_clear;
      logic was_write;
   } rsp_type;

endpackage

>>> hw/rtl/grid_line_of_sight_check_unit.sv
// Grid line-of-sight check unit.
// Request channel (req_valid / req_stall / req_data) carries either a cell
// write (operation = write) or a sight check between two points. Result
// channel (rsp_valid / rsp_stall / rsp_data) returns one result per request.
// A write goes from acceptance straight to the done state, which loads
// the result register and returns to idle; a check that fails on the
// floor test does the same. Otherwise each ray runs a setup state, a
// step and a test state per plane step and a climb and a climb-test
// state per floor climbed, plus a closing climb state when the ray is
// clear, since every visited cell is one registered read of the cell
// store; a second ray is run only when the first is blocked, and the
// result then goes through the done state. One request is in work at a time.
// After reset the cell store is cleared one cell a cycle, all 16384 cells,
// while req_stall stays high.
// The result sits in an output register; a new request is accepted while
// it waits. A finished result is held until the previous one is taken
// when the receiver keeps rsp_stall high.
module grid_line_of_sight_check_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  glos_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output glos_pkg::rsp_type rsp_data
);

   localparam int CW = glos_pkg::COORD_W;
   localparam int FW = glos_pkg::FLOOR_W;
   localparam int AW = glos_pkg::ADDR_W;
   localparam int EW = glos_pkg::ERR_W;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SETUP = 3'd2;
   localparam logic [2:0] ST_STEP  = 3'd3;
   localparam logic [2:0] ST_TEST  = 3'd4;
   localparam logic [2:0] ST_CLIMB = 3'd5;
   localparam logic [2:0] ST_CTEST = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   function automatic logic [EW-1:0] mag(input logic signed [EW-1:0] v);
      mag = v[EW-1] ? EW'(-v) : EW'(v);
   endfunction

   function automatic logic signed [EW-1:0] ext(input logic [CW-1:0] v);
      ext = $signed({{(EW-CW){1'b0}}, v});
   endfunction

   logic [2:0]              state_ff, state_in;
   logic [AW-1:0]           clr_addr_ff, clr_addr_in;
   glos_pkg::req_type       req_ff, req_in;
   logic                    ray_ff, ray_in;
   logic [CW-1:0]           sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic [FW-1:0]           sz_ff, sz_in, ez_ff, ez_in;
   logic                    x_dec_ff, x_dec_in, y_dec_ff, y_dec_in;
   logic signed [EW-1:0]    dex_ff, dex_in, dey_ff, dey_in, e_ff, e_in;
   logic                    first_clear_ff, first_clear_in;
   logic                    result_ff, result_in;
   logic                    wr_flag_ff, wr_flag_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   glos_pkg::rsp_type       rsp_data_ff, rsp_data_in;
   logic [1:0]              rd_ff;

   logic [1:0]              cell_mem [glos_pkg::CELL_COUNT];
   logic                    mem_we;
   logic [AW-1:0]           mem_wa, mem_ra;
   logic [1:0]              mem_wd;

   logic                    req_fire;
   logic                    ray_done, ray_ok;

   // setup datapath
   logic [CW-1:0]           ax, ay, bx, by, ssx, ssy, eex, eey;
   logic [FW-1:0]           az, bz, ssz, eez;
   logic signed [EW-1:0]    ka, kb;

   // step datapath
   logic signed [EW-1:0]    hor_s, ver_s, crs_s;
   logic [EW-1:0]           hor, ver, crs;
   logic                    y_move, x_move;
   logic [CW-1:0]           nx, ny;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      ax  = ray_ff ? req_ff.to_x   : req_ff.from_x;
      ay  = ray_ff ? req_ff.to_y   : req_ff.from_y;
      az  = ray_ff ? req_ff.to_z   : req_ff.from_z;
      bx  = ray_ff ? req_ff.from_x : req_ff.to_x;
      by  = ray_ff ? req_ff.from_y : req_ff.to_y;
      bz  = ray_ff ? req_ff.from_z : req_ff.to_z;
      // start from the lower floor
      ssx = (az > bz) ? bx : ax;
      ssy = (az > bz) ? by : ay;
      ssz = (az > bz) ? bz : az;
      eex = (az > bz) ? ax : bx;
      eey = (az > bz) ? ay : by;
      eez = (az > bz) ? az : bz;
      ka  = ext(eey) - ext(ssy);
      kb  = ext(ssx) - ext(eex);
   end

   // error is kept incrementally: zero at the start cell, x moves add dex (+/-ka), y moves add dey (+/-kb)
   always_comb begin
      hor_s  = e_ff + dex_ff;
      ver_s  = e_ff + dey_ff;
      crs_s  = e_ff + dex_ff + dey_ff;
      hor    = mag(hor_s);
      ver    = mag(ver_s);
      crs    = mag(crs_s);
      y_move = (sy_ff != ey_ff) && ((sx_ff == ex_ff) || (hor > ver) || (hor > crs));
      ny     = y_move ? (y_dec_ff ? sy_ff - CW'(1) : sy_ff + CW'(1)) : sy_ff;
      x_move = (sx_ff != ex_ff) && ((ny == ey_ff) || (ver > hor) || (ver > crs));
      nx     = x_move ? (x_dec_ff ? sx_ff - CW'(1) : sx_ff + CW'(1)) : sx_ff;
   end

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      req_in         = req_ff;
      ray_in         = ray_ff;
      sx_in          = sx_ff;
      sy_in          = sy_ff;
      sz_in          = sz_ff;
      ex_in          = ex_ff;
      ey_in          = ey_ff;
      ez_in          = ez_ff;
      x_dec_in       = x_dec_ff;
      y_dec_in       = y_dec_ff;
      dex_in         = dex_ff;
      dey_in         = dey_ff;
      e_in           = e_ff;
      first_clear_in = first_clear_ff;
      result_in      = result_ff;
      wr_flag_in     = wr_flag_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      mem_we         = 1'b0;
      mem_wa         = clr_addr_ff;
      mem_wd         = 2'b00;
      mem_ra         = {sz_ff, sy_ff, sx_ff};
      ray_done       = 1'b0;
      ray_ok         = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == {AW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               req_in = req_data;
               ray_in = 1'b0;
               if (req_data.operation == glos_pkg::OP_WRITE) begin
                  mem_we     = 1'b1;
                  mem_wa     = {req_data.from_z, req_data.from_y, req_data.from_x};
                  mem_wd     = {req_data.cell_occupied, req_data.cell_blocks};
                  result_in  = 1'b0;
                  wr_flag_in = 1'b1;
                  state_in   = ST_DONE;
               end else if (req_data.floor_check && (req_data.from_z != req_data.to_z)) begin
                  result_in  = 1'b0;
                  wr_flag_in = 1'b0;
                  state_in   = ST_DONE;
               end else begin
                  wr_flag_in = 1'b0;
                  state_in   = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            sx_in    = ssx;
            sy_in    = ssy;
            sz_in    = ssz;
            ex_in    = eex;
            ey_in    = eey;
            ez_in    = eez;
            x_dec_in = ssx > eex;
            y_dec_in = ssy > eey;
            dex_in   = (ssx < eex) ? ka : ((ssx == eex) ? '0 : -ka);
            dey_in   = (ssy < eey) ? kb : ((ssy == eey) ? '0 : -kb);
            e_in     = '0;
            if ((ax == bx) && (ay == by) && (az == bz)) begin
               ray_done = 1'b1;
               ray_ok   = 1'b1;
            end else if ((ssx != eex) || (ssy != eey)) begin
               state_in = ST_STEP;
            end else begin
               state_in = ST_CLIMB;
            end
         end
         ST_STEP: begin
            sx_in    = nx;
            sy_in    = ny;
            mem_ra   = {sz_ff, ny, nx};
            e_in     = e_ff + (y_move ? dey_ff : '0) + (x_move ? dex_ff : '0);
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (rd_ff[glos_pkg::MARK_BLOCKS]) begin
               ray_done = 1'b1;
            end else if ((sx_ff == ex_ff) && (sy_ff == ey_ff)) begin
               state_in = ST_CLIMB;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_CLIMB: begin
            if (sz_ff < ez_ff) begin
               state_in = ST_CTEST;
            end else begin
               ray_done = 1'b1;
               ray_ok   = 1'b1;
            end
         end
         ST_CTEST: begin
            if (rd_ff[glos_pkg::MARK_OCCUPIED]) begin
               ray_done = 1'b1;
            end else begin
               sz_in    = sz_ff + FW'(1);
               state_in = ST_CLIMB;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.sight_clear = result_ff;
               rsp_data_in.was_write   = wr_flag_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // second ray runs only when the first one is blocked
      if (ray_done) begin
         if (!ray_ff) begin
            first_clear_in = ray_ok;
         end
         if (!ray_ff && !ray_ok) begin
            ray_in   = 1'b1;
            state_in = ST_SETUP;
         end else begin
            result_in = ray_ok;
            state_in  = ST_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_wa] <= mem_wd;
      end
      rd_ff <= cell_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         first_clear_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         rsp_valid_ff   <= rsp_valid_in;
         first_clear_ff <= first_clear_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      ray_ff      <= ray_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      sz_ff       <= sz_in;
      ex_ff       <= ex_in;
      ey_ff       <= ey_in;
      ez_ff       <= ez_in;
      x_dec_ff    <= x_dec_in;
      y_dec_ff    <= y_dec_in;
      dex_ff      <= dex_in;
      dey_ff      <= dey_in;
      e_ff        <= e_in;
      result_ff   <= result_in;
      wr_flag_ff  <= wr_flag_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_write_ack: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_data.operation == glos_pkg::OP_WRITE))
      |=> (state_ff == ST_DONE) && wr_flag_ff && !result_ff)
      else $error("cell write not acknowledged as a write");

   a_climb_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CTEST) |-> (sz_ff < ez_ff))
      else $error("floor climb passed the end floor");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside the done state");

   a_walk_stops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> ((sx_ff != ex_ff) || (sy_ff != ey_ff)))
      else $error("plane step issued at the end column and row");

endmodule
